FILE: rtl/amdfs_pkg.sv
// ----------------------------------------------------------------------------
// Adjacency matrix DFS package
// Shared constants, command codes and the result type of the scan unit.
// ----------------------------------------------------------------------------
package amdfs_pkg;

    // Field widths fixed by the item format.
    localparam int NODE_W       = 7;
    localparam int WEIGHT_W     = 16;
    localparam int KIND_W       = 2;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_W        = 7;

    // Default matrix size.
    localparam int MAX_NODES_DEF = 64;

    // Register reset values.
    localparam logic [KIND_W-1:0] GRAPH_KIND_RST = 2'd0;
    localparam logic [NODE_W-1:0] NODE_COUNT_RST = 7'd64;

    // Bits of the graph kind register.
    localparam int KIND_DIRECTED_BIT = 0;
    localparam int KIND_WEIGHTED_BIT = 1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRAPH_KIND = 1'b0,
        REG_NODE_COUNT = 1'b1
    } t_cfg_reg;

    // Input item commands.
    typedef enum logic {
        CMD_EDGE     = 1'b0,
        CMD_TRAVERSE = 1'b1
    } t_cmd;

    // Result of one neighbor search.
    typedef struct packed {
        logic              found;
        logic [NODE_W-1:0] node;
    } t_scan_res;

endpackage

FILE: rtl/amdfs_scan.sv
// ----------------------------------------------------------------------------
// Neighbor scan unit
// Finds the lowest unvisited neighbor of a row above a scan position and
// within the node limit. Shared by every step of the traversal.
// ----------------------------------------------------------------------------
module amdfs_scan #(
    parameter int MAX_NODES = amdfs_pkg::MAX_NODES_DEF
) (
    input  logic [MAX_NODES-1:0]         i_row,
    input  logic [MAX_NODES-1:0]         i_visited,
    input  logic [amdfs_pkg::NODE_W-1:0] i_start,
    input  logic [amdfs_pkg::NODE_W-1:0] i_limit,
    output amdfs_pkg::t_scan_res         o_res
);

    localparam int NW = amdfs_pkg::NODE_W;

    logic [MAX_NODES-1:0] cand;

    // Bit b stands for node b+1: it qualifies when node b+1 lies above the
    // scan position and at or below the limit.
    always_comb begin
        for (int b = 0; b < MAX_NODES; b++) begin
            cand[b] = i_row[b] & ~i_visited[b] & (NW'(b) >= i_start) & (NW'(b) < i_limit);
        end
    end

    // Lowest set candidate wins.
    always_comb begin
        o_res.found = 1'b0;
        o_res.node  = '0;
        for (int b = MAX_NODES - 1; b >= 0; b--) begin
            if (cand[b]) begin
                o_res.found = 1'b1;
                o_res.node  = NW'(b + 1);
            end
        end
    end

endmodule

FILE: rtl/amdfs_matrix.sv
// ----------------------------------------------------------------------------
// Adjacency matrix store
// One row per node, one read and one write port, registered read data.
// Per-row valid flags make every row read as zero after reset.
// ----------------------------------------------------------------------------
module amdfs_matrix #(
    parameter int MAX_NODES = amdfs_pkg::MAX_NODES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_rd_en,
    input  logic [$clog2(MAX_NODES)-1:0] i_rd_addr,
    input  logic                         i_wr_en,
    input  logic [$clog2(MAX_NODES)-1:0] i_wr_addr,
    input  logic [MAX_NODES-1:0]         i_wr_data,
    output logic [MAX_NODES-1:0]         o_rd_data
);

    logic [MAX_NODES-1:0] r_rows [MAX_NODES];
    logic [MAX_NODES-1:0] r_row_valid;
    logic [MAX_NODES-1:0] r_rd_data;
    logic                 r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_rows[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_rows[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rd_valid  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_row_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_row_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

FILE: rtl/adjacency_matrix_dfs_order_core.sv
// ----------------------------------------------------------------------------
// Adjacency matrix depth-first order core
// Edge transactions build a bit adjacency matrix; a traverse transaction
// emits the depth-first visit order from a start node, last node flagged.
// ----------------------------------------------------------------------------
// An edge transaction holds the input through S_EDGE_A (directed kinds)
//   or S_EDGE_A and S_EDGE_B (undirected), one row read-modify-write each.
// A traversal fetches the start row, pushes each reached node from S_SCAN,
//   pops back through the stack memory via S_POP and ends with the final
//   flush; pushes and the flush wait while the output is stalled.
// The input is not ready until the current transaction is finished.
// Reset clears the row valid flags, so the matrix reads empty with no
//   clearing pass; graph_kind resets to 0 and node_count to 64.
// ----------------------------------------------------------------------------
module adjacency_matrix_dfs_order_core #(
    parameter int MAX_NODES = amdfs_pkg::MAX_NODES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port.
    input  logic                            i_cfg_we,
    input  logic [amdfs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [amdfs_pkg::CFG_W-1:0]     i_cfg_data,
    // Input stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: first_node[6:0], second_node[13:7], edge_weight[29:14], zero pad
    input  logic [31:0]                     s_axis_tdata,
    // tuser: command
    input  logic                            s_axis_tuser,
    // Output stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: visited_node[6:0], zero pad
    output logic [7:0]                      m_axis_tdata,
    output logic                            m_axis_tlast
);

    localparam int NW = amdfs_pkg::NODE_W;
    localparam int IW = $clog2(MAX_NODES);
    localparam int DW = $clog2(MAX_NODES + 1);
    localparam logic [MAX_NODES-1:0] ROW_ONE = MAX_NODES'(1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EDGE_A = 5'b00010,
        S_EDGE_B = 5'b00100,
        S_SCAN   = 5'b01000,
        S_POP    = 5'b10000
    } t_state;

    // A stack entry keeps a parent node and where its neighbor scan resumes.
    typedef struct packed {
        logic [NW-1:0] node;
        logic [NW-1:0] scan;
    } t_stack_entry;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state                            r_state, n_state;
    logic [amdfs_pkg::KIND_W-1:0]      r_graph_kind;
    logic [NW-1:0]                     r_node_count;
    logic [MAX_NODES-1:0]              r_visited, n_visited;
    logic [DW-1:0]                     r_depth, n_depth;
    logic [NW-1:0]                     r_cur_node, n_cur_node;
    logic [NW-1:0]                     r_cur_scan, n_cur_scan;
    logic [NW-1:0]                     r_pend_node, n_pend_node;
    logic                              r_out_valid, n_out_valid;
    logic [NW-1:0]                     r_out_node, n_out_node;
    logic                              r_out_last, n_out_last;
    logic [IW-1:0]                     r_edge_a, n_edge_a;
    logic [IW-1:0]                     r_edge_b, n_edge_b;
    logic                              r_present, n_present;
    t_stack_entry                      r_stack [MAX_NODES];
    t_stack_entry                      r_stack_rd;

    // ------------------------------------------------------------------
    // Input fields and decode
    // ------------------------------------------------------------------
    logic                              in_accept;
    amdfs_pkg::t_cmd                   in_cmd;
    logic [NW-1:0]                     in_first;
    logic [NW-1:0]                     in_second;
    logic [amdfs_pkg::WEIGHT_W-1:0]    in_weight;
    logic                              first_ok, second_ok;
    logic [NW-1:0]                     first_m1, second_m1;
    logic [NW-1:0]                     limit;
    logic                              out_free;

    assign in_accept = s_axis_tvalid & s_axis_tready;
    assign in_cmd    = amdfs_pkg::t_cmd'(s_axis_tuser);
    assign in_first  = s_axis_tdata[6:0];
    assign in_second = s_axis_tdata[13:7];
    assign in_weight = s_axis_tdata[29:14];

    // Nodes are numbered from 1; anything outside 1..MAX_NODES is ignored.
    assign first_ok  = (in_first != '0) && (in_first <= NW'(MAX_NODES));
    assign second_ok = (in_second != '0) && (in_second <= NW'(MAX_NODES));
    assign first_m1  = in_first - NW'(1);
    assign second_m1 = in_second - NW'(1);

    // The neighbor scan never runs past the matrix.
    assign limit = (r_node_count > NW'(MAX_NODES)) ? NW'(MAX_NODES) : r_node_count;

    // The output register can take a result this cycle.
    assign out_free = !r_out_valid || m_axis_tready;

    // ------------------------------------------------------------------
    // Matrix and scan unit
    // ------------------------------------------------------------------
    logic                              mat_rd_en;
    logic [IW-1:0]                     mat_rd_addr;
    logic                              mat_wr_en;
    logic [IW-1:0]                     mat_wr_addr;
    logic [MAX_NODES-1:0]              mat_wr_data;
    logic [MAX_NODES-1:0]              mat_row;
    amdfs_pkg::t_scan_res              scan_res;
    logic [NW-1:0]                     found_m1;

    amdfs_matrix #(
        .MAX_NODES (MAX_NODES)
    ) u_matrix (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (mat_rd_en),
        .i_rd_addr (mat_rd_addr),
        .i_wr_en   (mat_wr_en),
        .i_wr_addr (mat_wr_addr),
        .i_wr_data (mat_wr_data),
        .o_rd_data (mat_row)
    );

    // The row of the node on top of the stack is in mat_row whenever the
    // sequencer sits in the scan state.
    amdfs_scan #(
        .MAX_NODES (MAX_NODES)
    ) u_scan (
        .i_row     (mat_row),
        .i_visited (r_visited),
        .i_start   (r_cur_scan),
        .i_limit   (limit),
        .o_res     (scan_res)
    );

    assign found_m1 = scan_res.node - NW'(1);

    // ------------------------------------------------------------------
    // Stack port signals
    // ------------------------------------------------------------------
    logic                              stk_we;
    logic [IW-1:0]                     stk_widx;
    t_stack_entry                      stk_wdata;
    logic                              stk_re;
    logic [IW-1:0]                     stk_ridx;
    logic [DW-1:0]                     depth_m1, depth_m2;

    // The current node lives in r_cur_node/r_cur_scan; the memory holds its
    // ancestors, so the parent of the top sits at index depth-2.
    assign depth_m1 = r_depth - DW'(1);
    assign depth_m2 = r_depth - DW'(2);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_visited   = r_visited;
        n_depth     = r_depth;
        n_cur_node  = r_cur_node;
        n_cur_scan  = r_cur_scan;
        n_pend_node = r_pend_node;
        n_edge_a    = r_edge_a;
        n_edge_b    = r_edge_b;
        n_present   = r_present;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_node  = r_out_node;
        n_out_last  = r_out_last;
        mat_rd_en   = 1'b0;
        mat_rd_addr = '0;
        mat_wr_en   = 1'b0;
        mat_wr_addr = '0;
        mat_wr_data = mat_row;
        stk_we      = 1'b0;
        stk_widx    = '0;
        stk_wdata   = '0;
        stk_re      = 1'b0;
        stk_ridx    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (in_cmd == amdfs_pkg::CMD_EDGE) begin
                        if (first_ok && second_ok) begin
                            n_edge_a    = first_m1[IW-1:0];
                            n_edge_b    = second_m1[IW-1:0];
                            n_present   = r_graph_kind[amdfs_pkg::KIND_WEIGHTED_BIT] ?
                                          (in_weight != '0) : 1'b1;
                            mat_rd_en   = 1'b1;
                            mat_rd_addr = first_m1[IW-1:0];
                            n_state     = S_EDGE_A;
                        end
                    end else begin
                        // A traversal always starts from an empty visited map.
                        n_visited = '0;
                        n_depth   = '0;
                        if (first_ok) begin
                            n_visited   = ROW_ONE << first_m1[IW-1:0];
                            n_depth     = DW'(1);
                            n_cur_node  = in_first;
                            n_cur_scan  = '0;
                            n_pend_node = in_first;
                            mat_rd_en   = 1'b1;
                            mat_rd_addr = first_m1[IW-1:0];
                            n_state     = S_SCAN;
                        end
                    end
                end
            end

            S_EDGE_A: begin
                // Read-modify-write of the forward entry; an undirected kind
                // also fetches the mirror row.
                mat_wr_en   = 1'b1;
                mat_wr_addr = r_edge_a;
                mat_wr_data = (mat_row & ~(ROW_ONE << r_edge_b)) |
                              (MAX_NODES'(r_present) << r_edge_b);
                if (r_graph_kind[amdfs_pkg::KIND_DIRECTED_BIT]) begin
                    n_state = S_IDLE;
                end else begin
                    mat_rd_en   = 1'b1;
                    mat_rd_addr = r_edge_b;
                    n_state     = S_EDGE_B;
                end
            end

            S_EDGE_B: begin
                // For a self loop the mirror read saw the old row, which only
                // differs in the bit written here again.
                mat_wr_en   = 1'b1;
                mat_wr_addr = r_edge_b;
                mat_wr_data = (mat_row & ~(ROW_ONE << r_edge_a)) |
                              (MAX_NODES'(r_present) << r_edge_a);
                n_state     = S_IDLE;
            end

            S_SCAN: begin
                if (scan_res.found) begin
                    // Push: the previous node goes out and the new one waits,
                    // since only the end of the walk tells which one is last.
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_node  = r_pend_node;
                        n_out_last  = 1'b0;
                        n_pend_node = scan_res.node;
                        stk_we      = 1'b1;
                        stk_widx    = depth_m1[IW-1:0];
                        stk_wdata   = '{node: r_cur_node, scan: scan_res.node};
                        n_cur_node  = scan_res.node;
                        n_cur_scan  = '0;
                        n_depth     = r_depth + DW'(1);
                        n_visited   = r_visited | (ROW_ONE << found_m1[IW-1:0]);
                        mat_rd_en   = 1'b1;
                        mat_rd_addr = found_m1[IW-1:0];
                    end
                end else if (r_depth == DW'(1)) begin
                    // The start node is exhausted: flush the final result.
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_node  = r_pend_node;
                        n_out_last  = 1'b1;
                        n_depth     = '0;
                        n_state     = S_IDLE;
                    end
                end else begin
                    // Pop back to the parent.
                    stk_re   = 1'b1;
                    stk_ridx = depth_m2[IW-1:0];
                    n_depth  = depth_m1;
                    n_state  = S_POP;
                end
            end

            S_POP: begin
                n_cur_node  = r_stack_rd.node;
                n_cur_scan  = r_stack_rd.scan;
                mat_rd_en   = 1'b1;
                mat_rd_addr = IW'(r_stack_rd.node - NW'(1));
                n_state     = S_SCAN;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_graph_kind <= amdfs_pkg::GRAPH_KIND_RST;
            r_node_count <= amdfs_pkg::NODE_COUNT_RST;
            r_visited    <= '0;
            r_depth      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_visited   <= n_visited;
            r_depth     <= n_depth;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (amdfs_pkg::t_cfg_reg'(i_cfg_index))
                    amdfs_pkg::REG_GRAPH_KIND:
                        r_graph_kind <= i_cfg_data[amdfs_pkg::KIND_W-1:0];
                    amdfs_pkg::REG_NODE_COUNT:
                        r_node_count <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers and stack memory
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_cur_node  <= n_cur_node;
        r_cur_scan  <= n_cur_scan;
        r_pend_node <= n_pend_node;
        r_out_node  <= n_out_node;
        r_out_last  <= n_out_last;
        r_edge_a    <= n_edge_a;
        r_edge_b    <= n_edge_b;
        r_present   <= n_present;
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stack[stk_widx] <= stk_wdata;
        end
        if (stk_re) begin
            r_stack_rd <= r_stack[stk_ridx];
        end
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_node};
    assign m_axis_tlast  = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The walk never sits on an empty stack.
    a_scan_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_POP) |-> (r_depth != '0))
        else $error("traversal step with empty stack");

    // Between transactions the stack is empty.
    a_idle_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_depth == '0))
        else $error("stack not empty while idle");

    // The stack never grows beyond the matrix size.
    a_depth_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(MAX_NODES))
        else $error("stack depth overflow");

    // The scan unit never offers a node already visited.
    a_found_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && scan_res.found) |-> !r_visited[found_m1[IW-1:0]])
        else $error("scan returned a visited node");

    // A push deepens the stack by one and puts the pending node on the stack top.
    a_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && scan_res.found && out_free) |=>
        (r_depth == $past(r_depth) + DW'(1)) && (r_cur_node == r_pend_node))
        else $error("push did not update the stack top");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Depth-first order core testbench
// Loads edges into the adjacency matrix under every graph kind and a set of
// node counts, starts traversals, and checks each emitted node and its last
// flag against an in-bench depth-first walk over a private copy of the matrix.
// ----------------------------------------------------------------------------
module testbench;

    localparam int MAX_NODES     = amdfs_pkg::MAX_NODES_DEF;
    localparam int NODE_W        = amdfs_pkg::NODE_W;
    localparam int WEIGHT_W      = amdfs_pkg::WEIGHT_W;
    localparam int KIND_W        = amdfs_pkg::KIND_W;
    localparam int CFG_IDX_W     = amdfs_pkg::CFG_IDX_W;
    localparam int CFG_W         = amdfs_pkg::CFG_W;
    // Cycles of quiet after the last result before a register write, so that an
    // edge transaction still in flight can finish.
    localparam int SETTLE_CYCLES = 8;
    // Cycles without any accepted transaction before the run is given up.
    localparam int STALL_LIMIT   = 4000;
    localparam int IDLE_PCT      = 16;
    localparam int RAND_PHASES   = 10;
    localparam int PHASE_ITEMS   = 40;

    // Graph kind codes; bit 0 selects directed, bit 1 selects weighted.
    localparam logic [KIND_W-1:0] KIND_UNDIR_UNWEIGHTED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DIR_UNWEIGHTED   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UNDIR_WEIGHTED   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DIR_WEIGHTED     = 2'd3;

    // One emitted node as the output stream should carry it.
    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic              last;
    } t_visit;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_W-1:0]      i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;
    logic                  m_axis_tlast;

    // Private copy of the block state and registers.
    logic [MAX_NODES-1:0]  adj_rows [MAX_NODES] = '{default: '0};
    logic [KIND_W-1:0]     graph_kind = amdfs_pkg::GRAPH_KIND_RST;
    logic [NODE_W-1:0]     node_count = amdfs_pkg::NODE_COUNT_RST;

    // Visit order still owed by the block, oldest first.
    t_visit                dfs_order_q [$];
    int                    mismatches  = 0;
    int                    quiet_cycles = 0;
    // When set, neither side of the stream inserts idle cycles.
    bit                    no_idle     = 1'b0;

    adjacency_matrix_dfs_order_core #(
        .MAX_NODES(MAX_NODES)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        // tdata: first_node[6:0], second_node[13:7], edge_weight[29:14], zero pad
        .s_axis_tdata (s_axis_tdata),
        // tuser: command
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        // tdata: visited_node[6:0], zero pad
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    // The receiver stalls at random, one decision per falling edge.
    always @(negedge i_clk) begin
        m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic logic node_in_range(input logic [NODE_W-1:0] n);
        return (n >= 1) && (n <= MAX_NODES);
    endfunction

    // Applies one accepted input transaction to the private state. Edges update
    // the matrix; a traversal walks it depth first with an explicit stack and
    // queues every node on its first visit.
    task automatic predict_item(input amdfs_pkg::t_cmd cmd, input logic [NODE_W-1:0] a,
                                input logic [NODE_W-1:0] b,
                                input logic [WEIGHT_W-1:0] w);
        logic [NODE_W-1:0]    path [MAX_NODES];
        logic [NODE_W-1:0]    scan [MAX_NODES];
        t_visit               order [MAX_NODES];
        logic [MAX_NODES-1:0] seen;
        logic [MAX_NODES-1:0] row;
        logic                 present;
        int                   depth;
        int                   lim;
        int                   j;
        int                   hit;
        int                   cnt;
        if (cmd == amdfs_pkg::CMD_EDGE) begin
            if (node_in_range(a) && node_in_range(b)) begin
                // Weighted kinds only remember whether the weight is nonzero.
                present = graph_kind[amdfs_pkg::KIND_WEIGHTED_BIT] ? (w != '0) : 1'b1;
                adj_rows[a - 1][b - 1] = present;
                if (!graph_kind[amdfs_pkg::KIND_DIRECTED_BIT]) begin
                    adj_rows[b - 1][a - 1] = present;
                end
            end
        end else if (node_in_range(a)) begin
            lim = (node_count > MAX_NODES) ? MAX_NODES : node_count;
            seen = '0;
            seen[a - 1] = 1'b1;
            path[0] = a;
            scan[0] = '0;
            depth = 1;
            order[0] = '{node: a, last: 1'b0};
            cnt = 1;
            while (depth > 0) begin
                row = adj_rows[path[depth - 1] - 1];
                hit = 0;
                // Resume the neighbor scan just past the last child taken.
                for (j = scan[depth - 1] + 1; j <= lim && hit == 0; j++) begin
                    if (row[j - 1] && !seen[j - 1]) hit = j;
                end
                if (hit == 0 || depth >= MAX_NODES) begin
                    depth--;
                end else begin
                    scan[depth - 1] = NODE_W'(hit);
                    seen[hit - 1] = 1'b1;
                    path[depth] = NODE_W'(hit);
                    scan[depth] = '0;
                    depth++;
                    order[cnt] = '{node: NODE_W'(hit), last: 1'b0};
                    cnt++;
                end
            end
            order[cnt - 1].last = 1'b1;
            for (j = 0; j < cnt; j++) dfs_order_q.push_back(order[j]);
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // Presents one item and returns at the rising edge where it is accepted.
    // The valid line is left high so that a following item can go back to back.
    task automatic send_item(input amdfs_pkg::t_cmd cmd, input logic [NODE_W-1:0] a,
                             input logic [NODE_W-1:0] b,
                             input logic [WEIGHT_W-1:0] w);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {2'b00, w, b, a};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_item(cmd, a, b, w);
    endtask

    // Stops the sender and waits until every owed result has come out, then
    // lets the block finish any edge transaction still in flight.
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (dfs_order_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input amdfs_pkg::t_cfg_reg idx,
                             input logic [CFG_W-1:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        if (idx == amdfs_pkg::REG_GRAPH_KIND) graph_kind = value[KIND_W-1:0];
        else node_count = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [NODE_W-1:0] pick_node(input int span);
        return NODE_W'($urandom_range(span, 1));
    endfunction

    // Hand-picked cases: node extremes, nodes out of range, self loops, each
    // graph kind, zero weights clearing an edge, node counts of zero, one and
    // above the matrix size, and a start node above the node count.
    task automatic test_directed_cases();
        send_item(amdfs_pkg::CMD_EDGE, 7'd1, 7'd64, 16'h0000);
        send_item(amdfs_pkg::CMD_EDGE, 7'd64, 7'd64, 16'hFFFF);
        send_item(amdfs_pkg::CMD_EDGE, 7'd1, 7'd2, 16'h0001);
        send_item(amdfs_pkg::CMD_EDGE, 7'd0, 7'd5, 16'h1234);
        send_item(amdfs_pkg::CMD_EDGE, 7'd5, 7'd127, 16'h8000);
        send_item(amdfs_pkg::CMD_EDGE, 7'd65, 7'd1, 16'hFFFF);
        send_item(amdfs_pkg::CMD_TRAVERSE, 7'd1, 7'd0, 16'h0000);
        send_item(amdfs_pkg::CMD_TRAVERSE, 7'd0, 7'd127, 16'hFFFF);
        send_item(amdfs_pkg::CMD_TRAVERSE, 7'd127, 7'd1, 16'h0000);
        send_item(amdfs_pkg::CMD_TRAVERSE, 7'd64, 7'd64, 16'h0000);
        write_reg(amdfs_pkg::REG_GRAPH_KIND, CFG_W'(KIND_DIR_UNWEIGHTED));
        send_item(amdfs_pkg::CMD_EDGE, 7'd3, 7'd1, 16'h0000);
        send_item(amdfs_pkg::CMD_TRAVERSE, 7'd3, 7'd0, 16'h0000);
        write_reg(amdfs_pkg::REG_GRAPH_KIND, CFG_W'(KIND_UNDIR_WEIGHTED));
        send_item(amdfs_pkg::CMD_EDGE, 7'd1, 7'd2, 16'h0000);
        send_item(amdfs_pkg::CMD_TRAVERSE, 7'd1, 7'd0, 16'h0000);
        write_reg(amdfs_pkg::REG_GRAPH_KIND, CFG_W'(KIND_DIR_WEIGHTED));
        send_item(amdfs_pkg::CMD_EDGE, 7'd2, 7'd3, 16'hFFFF);
        send_item(amdfs_pkg::CMD_TRAVERSE, 7'd2, 7'd0, 16'h0000);
        write_reg(amdfs_pkg::REG_NODE_COUNT, 7'd0);
        send_item(amdfs_pkg::CMD_TRAVERSE, 7'd1, 7'd0, 16'h0000);
        write_reg(amdfs_pkg::REG_NODE_COUNT, 7'd127);
        send_item(amdfs_pkg::CMD_TRAVERSE, 7'd3, 7'd0, 16'h0000);
        write_reg(amdfs_pkg::REG_NODE_COUNT, 7'd1);
        send_item(amdfs_pkg::CMD_TRAVERSE, 7'd64, 7'd0, 16'h0000);
        send_item(amdfs_pkg::CMD_TRAVERSE, 7'd2, 7'd0, 16'h0000);
    endtask

    // A directed chain through every node gives the longest possible order,
    // with the stack at its full depth.
    task automatic test_full_chain();
        int n;
        write_reg(amdfs_pkg::REG_GRAPH_KIND, CFG_W'(KIND_DIR_UNWEIGHTED));
        write_reg(amdfs_pkg::REG_NODE_COUNT, 7'd64);
        for (n = 1; n < MAX_NODES; n++) begin
            send_item(amdfs_pkg::CMD_EDGE, NODE_W'(n), NODE_W'(n + 1),
                      16'($urandom_range(65535)));
        end
        send_item(amdfs_pkg::CMD_TRAVERSE, 7'd1, 7'd0, 16'h0000);
        send_item(amdfs_pkg::CMD_TRAVERSE, 7'd32, 7'd0, 16'h0000);
    endtask

    // Random phases, each under its own graph kind and node count. Most items
    // are edges and traversals among nodes up to just past the node count; the rest are
    // noise with any field value.
    task automatic test_random_phases();
        int                  p;
        int                  k;
        int                  span;
        logic [KIND_W-1:0]   kind;
        logic [CFG_W-1:0]    count;
        logic [WEIGHT_W-1:0] w;
        for (p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: begin kind = KIND_UNDIR_UNWEIGHTED; count = 7'd1;   end
                1: begin kind = KIND_DIR_WEIGHTED;     count = 7'd64;  end
                2: begin kind = KIND_UNDIR_WEIGHTED;   count = 7'd0;   end
                3: begin kind = KIND_DIR_UNWEIGHTED;   count = 7'd127; end
                default: begin
                    kind = KIND_W'($urandom_range(3));
                    if ($urandom_range(3) == 0) count = CFG_W'($urandom_range(64, 17));
                    else count = CFG_W'($urandom_range(16, 2));
                end
            endcase
            // The upper data bits of the kind register are don't-care.
            write_reg(amdfs_pkg::REG_GRAPH_KIND,
                      {(CFG_W - KIND_W)'($urandom_range(31)), kind});
            write_reg(amdfs_pkg::REG_NODE_COUNT, count);
            span = (count == 0) ? 8 : ((count > MAX_NODES) ? MAX_NODES : count);
            // Reach a little past the node count to start above it now and then.
            if (span + 2 <= MAX_NODES) span = span + 2;
            no_idle = (p == 4);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                // Hold off once per phase until every owed result is out.
                if (k == PHASE_ITEMS / 2) drain_results();
                w = ($urandom_range(3) == 0) ? '0 : WEIGHT_W'($urandom_range(65535));
                if ($urandom_range(99) < 15) begin
                    send_item(amdfs_pkg::t_cmd'($urandom_range(1)),
                              NODE_W'($urandom_range(127)),
                              NODE_W'($urandom_range(127)), w);
                end else if ($urandom_range(99) < 30) begin
                    send_item(amdfs_pkg::CMD_TRAVERSE, pick_node(span), pick_node(span), w);
                end else begin
                    send_item(amdfs_pkg::CMD_EDGE, pick_node(span), pick_node(span), w);
                end
            end
            no_idle = 1'b0;
        end
    endtask

    // Every accepted output transaction is matched against the oldest owed node.
    always @(posedge i_clk) begin : check_results
        t_visit exp_v;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (dfs_order_q.size() == 0) begin
                report_mismatch($sformatf("unexpected node %0d", m_axis_tdata));
            end else begin
                exp_v = dfs_order_q.pop_front();
                if (m_axis_tdata !== {1'b0, exp_v.node})
                    report_mismatch($sformatf("node %0d, wanted %0d",
                                              m_axis_tdata, exp_v.node));
                if (m_axis_tlast !== exp_v.last)
                    report_mismatch($sformatf("last %b, wanted %b on node %0d",
                                              m_axis_tlast, exp_v.last, exp_v.node));
            end
        end
    end

    // Watchdog: any transaction on either stream or the register port counts
    // as progress; a long silence means the block has hung.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            i_cfg_we || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_full_chain();
        test_random_phases();
        drain_results();
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
